// ----- src/lsau_pkg.sv -----
// Shared types and codes for the load/store address unit.
// No dependencies; imported by lsau_shifter and load_store_address_unit.
package lsau_pkg;

   // access size codes
   localparam logic [1:0] SIZE_WORD = 2'd0;
   localparam logic [1:0] SIZE_BYTE = 2'd1;
   localparam logic [1:0] SIZE_HALF = 2'd2;

   // scaled register offset shift kinds, instruction bits 6..5
   localparam logic [1:0] SHIFT_LSL = 2'd0;
   localparam logic [1:0] SHIFT_LSR = 2'd1;
   localparam logic [1:0] SHIFT_ASR = 2'd2;
   localparam logic [1:0] SHIFT_ROR = 2'd3;

   localparam int unsigned REQ_DATA_W = 136;
   localparam int unsigned RSP_DATA_W = 112;

   typedef struct packed {
      logic [31:0] rm;
      logic [1:0]  kind;
      logic [4:0]  amount;
      logic        carry;
   } shift_req_type;

   // offset stage: decoded controls plus selected offset
   typedef struct packed {
      logic [31:0] base;
      logic [31:0] offset;
      logic [31:0] wdata;
      logic [1:0]  size;
      logic        up;
      logic        pre;
      logic        wbit;
      logic        load;
      logic [3:0]  target;
      logic [3:0]  basereg;
   } stage_a_type;

   // add stage: offset folded into the indexed base
   typedef struct packed {
      logic [31:0] base;
      logic [31:0] indexed;
      logic [31:0] wdata;
      logic [1:0]  size;
      logic        pre;
      logic        wbit;
      logic        load;
      logic [3:0]  target;
      logic [3:0]  basereg;
   } stage_b_type;

   // result stage
   typedef struct packed {
      logic [31:0] address;
      logic [1:0]  size;
      logic        load;
      logic [3:0]  target;
      logic [3:0]  basereg;
      logic        writeback;
      logic [31:0] new_base;
      logic [31:0] wdata;
      logic        status;
   } stage_c_type;

endpackage

// ----- src/lsau_shifter.sv -----
// Barrel shifter for scaled register offsets (LSL, LSR, ASR, ROR, RRX).
// Depends on lsau_pkg for the shift request struct and shift codes.
module lsau_shifter (
   input  lsau_pkg::shift_req_type shift_req,
   output logic [31:0]             shift_out
);
   import lsau_pkg::*;

   logic [63:0] rot_wide;

   assign rot_wide = {shift_req.rm, shift_req.rm} >> shift_req.amount;

   always_comb begin
      unique case (shift_req.kind)
         SHIFT_LSL: shift_out = shift_req.rm << shift_req.amount;
         SHIFT_LSR: begin
            // amount zero encodes LSR #32
            if (shift_req.amount == 5'd0) shift_out = 32'd0;
            else                          shift_out = shift_req.rm >> shift_req.amount;
         end
         SHIFT_ASR: begin
            // amount zero encodes ASR #32
            if (shift_req.amount == 5'd0) shift_out = {32{shift_req.rm[31]}};
            else shift_out = 32'($signed(shift_req.rm) >>> shift_req.amount);
         end
         default: begin
            // amount zero encodes RRX
            if (shift_req.amount == 5'd0) shift_out = {shift_req.carry, shift_req.rm[31:1]};
            else                          shift_out = rot_wide[31:0];
         end
      endcase
   end

endmodule

// ----- src/load_store_address_unit.sv -----
// Load/store address unit: addressing modes for single word, byte and halfword transfers.
// Pipeline: each req beat passes through the offset, add and result stage registers to rsp_tvalid.
// Throughput: one beat per cycle; each stage holds when the one after it is full and stalled.
// Reset: synchronous, clears the three stage valid bits; payload registers are not reset.
// Depends on lsau_pkg and lsau_shifter.
module load_store_address_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // from bit 0: instruction[31:0], base_value[63:32], offset_value[95:64],
   // store_value[127:96], carry_flag[128], zero pad[135:129]
   input  logic [lsau_pkg::REQ_DATA_W-1:0]     req_tdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // from bit 0: access_address[31:0], access_size[33:32], is_load[34],
   // target_register[38:35], base_register[42:39], base_writeback[43],
   // new_base[75:44], write_data[107:76], status[108], zero pad[111:109]
   output logic [lsau_pkg::RSP_DATA_W-1:0]     rsp_tdata
);
   import lsau_pkg::*;

   // unpacked request fields
   logic [31:0] ins;
   logic [31:0] base_val;
   logic [31:0] rm_val;
   logic [31:0] store_val;
   logic        carry;

   assign ins       = req_tdata[31:0];
   assign base_val  = req_tdata[63:32];
   assign rm_val    = req_tdata[95:64];
   assign store_val = req_tdata[127:96];
   assign carry     = req_tdata[128];

   // stage registers and valid bits
   stage_a_type stage_a_ff, stage_a_in;
   stage_b_type stage_b_ff, stage_b_in;
   stage_c_type stage_c_ff, stage_c_in;
   logic        valid_a_ff, valid_a_in;
   logic        valid_b_ff, valid_b_in;
   logic        valid_c_ff, valid_c_in;

   // a stage moves when it is empty or the next one moves
   logic adv_a, adv_b, adv_c;

   assign adv_c = !valid_c_ff || rsp_tready;
   assign adv_b = !valid_b_ff || adv_c;
   assign adv_a = !valid_a_ff || adv_b;

   assign req_tready = adv_a;

   // ---------------- offset stage: decode and scaled shift ----------------
   shift_req_type shift_req;
   logic [31:0]   shift_out;

   assign shift_req.rm     = rm_val;
   assign shift_req.kind   = ins[6:5];
   assign shift_req.amount = ins[11:7];
   assign shift_req.carry  = carry;

   lsau_shifter u_shifter (
      .shift_req (shift_req),
      .shift_out (shift_out)
   );

   always_comb begin
      stage_a_in.base    = base_val;
      stage_a_in.up      = ins[23];
      stage_a_in.pre     = ins[24];
      stage_a_in.wbit    = ins[21];
      stage_a_in.load    = ins[20];
      stage_a_in.target  = ins[15:12];
      stage_a_in.basereg = ins[19:16];

      if (ins[26]) begin
         // word/byte: immediate, plain register or scaled register
         stage_a_in.size = ins[22] ? SIZE_BYTE : SIZE_WORD;
         if (!ins[25])              stage_a_in.offset = {20'd0, ins[11:0]};
         else if (ins[11:5] == 7'd0) stage_a_in.offset = rm_val;
         else                        stage_a_in.offset = shift_out;
      end else begin
         // halfword: split 8-bit immediate or plain register
         stage_a_in.size = SIZE_HALF;
         if (ins[22]) stage_a_in.offset = {24'd0, ins[11:8], ins[3:0]};
         else         stage_a_in.offset = rm_val;
      end

      // store data cut to the access size; zero for loads
      if (ins[20])                          stage_a_in.wdata = 32'd0;
      else if (stage_a_in.size == SIZE_WORD) stage_a_in.wdata = store_val;
      else if (stage_a_in.size == SIZE_BYTE) stage_a_in.wdata = {24'd0, store_val[7:0]};
      else                                   stage_a_in.wdata = {16'd0, store_val[15:0]};
   end

   // ---------------- add stage ----------------
   always_comb begin
      stage_b_in.base    = stage_a_ff.base;
      stage_b_in.indexed = stage_a_ff.up ? stage_a_ff.base + stage_a_ff.offset
                                         : stage_a_ff.base - stage_a_ff.offset;
      stage_b_in.wdata   = stage_a_ff.wdata;
      stage_b_in.size    = stage_a_ff.size;
      stage_b_in.pre     = stage_a_ff.pre;
      stage_b_in.wbit    = stage_a_ff.wbit;
      stage_b_in.load    = stage_a_ff.load;
      stage_b_in.target  = stage_a_ff.target;
      stage_b_in.basereg = stage_a_ff.basereg;
   end

   // ---------------- result stage: address, abort, writeback ----------------
   always_comb begin
      // post-index uses the plain base and writes back unless it aborts
      stage_c_in.address   = stage_b_ff.pre ? stage_b_ff.indexed : stage_b_ff.base;
      stage_c_in.status    = (stage_b_ff.size == SIZE_HALF) && stage_c_in.address[0];
      // a misaligned halfword abort leaves the base alone
      stage_c_in.writeback = (!stage_b_ff.pre || stage_b_ff.wbit) && !stage_c_in.status;
      stage_c_in.new_base  = stage_c_in.writeback ? stage_b_ff.indexed : stage_b_ff.base;
      stage_c_in.size      = stage_b_ff.size;
      stage_c_in.load      = stage_b_ff.load;
      stage_c_in.target    = stage_b_ff.target;
      stage_c_in.basereg   = stage_b_ff.basereg;
      stage_c_in.wdata     = stage_b_ff.wdata;
   end

   // valid bits follow the data
   assign valid_a_in = adv_a ? req_tvalid : valid_a_ff;
   assign valid_b_in = adv_b ? valid_a_ff : valid_b_ff;
   assign valid_c_in = adv_c ? valid_b_ff : valid_c_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
         valid_c_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
         valid_c_ff <= valid_c_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv_a) stage_a_ff <= stage_a_in;
      if (adv_b) stage_b_ff <= stage_b_in;
      if (adv_c) stage_c_ff <= stage_c_in;
   end

   // response beat
   assign rsp_tvalid = valid_c_ff;
   assign rsp_tdata  = {3'd0,
                        stage_c_ff.status,
                        stage_c_ff.wdata,
                        stage_c_ff.new_base,
                        stage_c_ff.writeback,
                        stage_c_ff.basereg,
                        stage_c_ff.target,
                        stage_c_ff.load,
                        stage_c_ff.size,
                        stage_c_ff.address};

   // ---------------- assertions ----------------
   a_reset_empty: assert property (@(posedge clock)
      $past(reset) |-> !valid_a_ff && !valid_b_ff && !valid_c_ff)
      else $error("pipeline not empty after reset");

   a_abort_no_wb: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff && stage_c_ff.status |-> !stage_c_ff.writeback
                                          && stage_c_ff.size == SIZE_HALF)
      else $error("abort with writeback or on a non-halfword access");

   a_load_no_data: assert property (@(posedge clock) disable iff (reset)
      valid_c_ff && stage_c_ff.load |-> stage_c_ff.wdata == 32'd0)
      else $error("load carries store data");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      valid_b_ff && valid_c_ff && !rsp_tready |=> valid_b_ff && $stable(stage_b_ff))
      else $error("add stage lost its beat under a stall");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking bench for load_store_address_unit: directed table, then random load/store beats.
// Needs lsau_pkg and load_store_address_unit (with lsau_shifter) from the RTL.
`timescale 1ns / 100ps

module tb_top;
   import lsau_pkg::*;

   localparam logic STATUS_OK    = 1'b0;
   localparam logic STATUS_ABORT = 1'b1;

   localparam int RANDOM_BEATS   = 550;
   localparam int LONG_HOLD      = 60;    // output hold-off, long enough to back up the pipe
   localparam int DRAIN_CYCLES   = 10;    // margin after the last expected result
   localparam int WATCHDOG_LIMIT = 2000;  // cycles without any beat on either side

   // req beat layout, first field in the low bits
   typedef struct packed {
      logic [6:0]  pad;
      logic        carry_flag;
      logic [31:0] store_value;
      logic [31:0] offset_value;
      logic [31:0] base_value;
      logic [31:0] instruction;
   } ls_request_type;

   // rsp beat layout, first field in the low bits
   typedef struct packed {
      logic [2:0]  pad;
      logic        status;
      logic [31:0] wdata;
      logic [31:0] new_base;
      logic        writeback;
      logic [3:0]  basereg;
      logic [3:0]  target;
      logic        load;
      logic [1:0]  size;
      logic [31:0] address;
   } access_result_type;

   typedef struct {
      ls_request_type    req;
      bit                typed;   // want below is hand-written, else use the predictor
      access_result_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   // instruction, base_value, offset_value, store_value, carry_flag, pad
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   // address, size, is_load, target, base reg, writeback, new_base, wdata, status, pad
   logic [RSP_DATA_W-1:0] rsp_tdata;

   load_store_address_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   access_result_type expected_access[$];
   stim_row_type      directed_rows[$];

   int mismatches    = 0;
   int beats_sent    = 0;
   int results_seen  = 0;
   int aborts_seen   = 0;
   int writebacks    = 0;
   int in_stalls     = 0;
   int wordbyte_rand = 0;
   int half_rand     = 0;
   int raw_rand      = 0;
   int tx_idle_pct   = 0;
   int hold_requests = 0;

   // ---------------------------------------------------------------- predictor

   // scaled register offset; amount zero is the special case for LSR, ASR and ROR
   function automatic logic [31:0] shifted_index(logic [1:0] kind, logic [4:0] amt,
                                                 logic [31:0] rm, logic carry);
      case (kind)
         SHIFT_LSL: return rm << amt;
         SHIFT_LSR: return (amt == 5'd0) ? 32'd0 : rm >> amt;
         SHIFT_ASR: return (amt == 5'd0) ? {32{rm[31]}} : 32'($signed(rm) >>> amt);
         default:   return (amt == 5'd0) ? {carry, rm[31:1]}
                                         : (rm >> amt) | (rm << (32 - amt));
      endcase
   endfunction

   function automatic access_result_type predict_access(ls_request_type r);
      logic [31:0]       ins;
      logic [31:0]       offset;
      logic [31:0]       indexed;
      access_result_type res;
      ins = r.instruction;
      res = '0;
      if (ins[26]) begin
         // word/byte: immediate, plain register or scaled register
         res.size = ins[22] ? SIZE_BYTE : SIZE_WORD;
         if (!ins[25])
            offset = {20'd0, ins[11:0]};
         else if (ins[11:5] == 7'd0)
            offset = r.offset_value;
         else
            offset = shifted_index(ins[6:5], ins[11:7], r.offset_value, r.carry_flag);
      end else begin
         // halfword: split 8-bit immediate or plain register
         res.size = SIZE_HALF;
         offset   = ins[22] ? {24'd0, ins[11:8], ins[3:0]} : r.offset_value;
      end
      indexed       = ins[23] ? r.base_value + offset : r.base_value - offset;
      res.address   = ins[24] ? indexed : r.base_value;   // post-index uses the old base
      res.writeback = !ins[24] || ins[21];
      res.status    = (res.size == SIZE_HALF && res.address[0]) ? STATUS_ABORT : STATUS_OK;
      if (res.status == STATUS_ABORT)
         res.writeback = 1'b0;                            // abort leaves the base alone
      res.new_base = res.writeback ? indexed : r.base_value;
      res.load     = ins[20];
      res.target   = ins[15:12];
      res.basereg  = ins[19:16];
      if (res.load)
         res.wdata = 32'd0;
      else if (res.size == SIZE_WORD)
         res.wdata = r.store_value;
      else if (res.size == SIZE_BYTE)
         res.wdata = {24'd0, r.store_value[7:0]};
      else
         res.wdata = {16'd0, r.store_value[15:0]};
      return res;
   endfunction

   // ---------------------------------------------------------------- stimulus helpers

   function automatic ls_request_type make_request(logic [31:0] ins, logic [31:0] base,
                                                   logic [31:0] rm, logic [31:0] sv, logic c);
      ls_request_type r;
      r              = '0;
      r.instruction  = ins;
      r.base_value   = base;
      r.offset_value = rm;
      r.store_value  = sv;
      r.carry_flag   = c;
      return r;
   endfunction

   function automatic access_result_type make_result(logic [31:0] addr, logic [1:0] size,
         logic load, logic [3:0] tgt, logic [3:0] bas, logic wb, logic [31:0] nb,
         logic [31:0] wd, logic st);
      access_result_type res;
      res           = '0;
      res.address   = addr;
      res.size      = size;
      res.load      = load;
      res.target    = tgt;
      res.basereg   = bas;
      res.writeback = wb;
      res.new_base  = nb;
      res.wdata     = wd;
      res.status    = st;
      return res;
   endfunction

   // mostly short gaps, now and then a long one
   function automatic int gap_len();
      return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 9))
         0:       return 32'hFFFF_FFFF;
         1:       return 32'h0000_0000;
         2:       return {8'($urandom_range(0, 255)), 20'd0, 4'($urandom_range(0, 15))};
         default: return $urandom;
      endcase
   endfunction

   // mostly well-formed word/byte and halfword encodings, some raw words
   function automatic ls_request_type random_request();
      logic [31:0] ins;
      int          pick;
      ins  = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         ins[27:26] = 2'b01;
         if ($urandom_range(0, 3) == 0)
            ins[11:7] = 5'd0;          // LSR/ASR #32 and RRX
         if (ins[25] && $urandom_range(0, 7) == 0)
            ins[11:4] = 8'd0;          // plain register offset
         wordbyte_rand++;
      end else if (pick < 92) begin
         ins[27:25] = 3'b000;
         ins[7:4]   = 4'b1011;
         half_rand++;
      end else begin
         raw_rand++;
      end
      return make_request(ins, pick_word(), pick_word(), $urandom, 1'($urandom_range(0, 1)));
   endfunction

   // one req beat: optional idle gap, then hold until accepted and log the expectation
   task automatic send_beat(input ls_request_type r, input bit typed,
                            input access_result_type want);
      int gap;
      if ($urandom_range(0, 99) < tx_idle_pct) begin
         gap        = gap_len();
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata  <= r;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      expected_access.push_back(typed ? want : predict_access(r));
      beats_sent++;
      @(negedge clock);
   endtask

   function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         mismatches++;
      end
   endfunction

   // ---------------------------------------------------------------- result checker

   always @(posedge clock) begin : check_rsp
      access_result_type got;
      access_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         results_seen++;
         if (got.status == STATUS_ABORT) aborts_seen++;
         if (got.writeback) writebacks++;
         if (expected_access.size() == 0) begin
            $error("rsp beat with nothing expected: 0x%0h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_access.pop_front();
            check_field("access_address",  want.address,         got.address);
            check_field("access_size",     32'(want.size),       32'(got.size));
            check_field("is_load",         32'(want.load),       32'(got.load));
            check_field("target_register", 32'(want.target),     32'(got.target));
            check_field("base_register",   32'(want.basereg),    32'(got.basereg));
            check_field("base_writeback",  32'(want.writeback),  32'(got.writeback));
            check_field("new_base",        want.new_base,        got.new_base);
            check_field("write_data",      want.wdata,           got.wdata);
            check_field("status",          32'(want.status),     32'(got.status));
         end
      end
   end

   // ---------------------------------------------------------------- receiver

   // rsp_tready: phases of no stall, light and heavy stall, plus the long hold on request
   int rx_wait      = 0;
   int rx_phase     = 0;
   int rx_stall_pct = 0;
   int holds_done   = 0;

   always @(negedge clock) begin : drive_ready
      logic ready;
      if (reset) begin
         ready = 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait--;
         ready = 1'b0;
      end else if (holds_done != hold_requests) begin
         holds_done++;
         rx_wait = LONG_HOLD - 1;
         ready   = 1'b0;
      end else begin
         if (rx_phase == 0) begin
            rx_phase = 64;
            case ($urandom_range(0, 2))
               0:       rx_stall_pct = 0;
               1:       rx_stall_pct = 10;
               default: rx_stall_pct = 35;
            endcase
         end
         rx_phase--;
         ready = 1'b1;
         if ($urandom_range(0, 99) < rx_stall_pct) begin
            ready   = 1'b0;
            rx_wait = gap_len() - 1;
         end
      end
      rsp_tready <= ready;
   end

   // ---------------------------------------------------------------- watchdog

   int quiet_cycles = 0;

   always @(posedge clock) begin
      if (req_tvalid && !req_tready)
         in_stalls++;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout: no beat moved for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      // directed table; hand-written results only where they are obvious
      directed_rows = '{
         // LDR r2,[r1,#4]
         '{make_request(32'hE591_2004, 32'h0000_1000, 32'h0, 32'h0, 1'b0), 1'b1,
           make_result(32'h0000_1004, SIZE_WORD, 1'b1, 4'd2, 4'd1, 1'b0,
                       32'h0000_1000, 32'h0, STATUS_OK)},
         // STR r4,[r3,#-4095]! from base zero wraps
         '{make_request(32'hE523_4FFF, 32'h0000_0000, 32'h0, 32'hDEAD_BEEF, 1'b0), 1'b1,
           make_result(32'hFFFF_F001, SIZE_WORD, 1'b0, 4'd4, 4'd3, 1'b1,
                       32'hFFFF_F001, 32'hDEAD_BEEF, STATUS_OK)},
         // STRB r6,[r5],#1 from all-ones base: post-index, new base wraps to zero
         '{make_request(32'hE4C5_6001, 32'hFFFF_FFFF, 32'h0, 32'h1234_5678, 1'b0), 1'b1,
           make_result(32'hFFFF_FFFF, SIZE_BYTE, 1'b0, 4'd6, 4'd5, 1'b1,
                       32'h0000_0000, 32'h0000_0078, STATUS_OK)},
         // LDRB plain register offset
         '{make_request(32'hE7D7_8009, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 1'b1), 1'b0, '0},
         // LDR scaled LSL #31, pre-index writeback
         '{make_request(32'hE7BA_BF80, 32'h0000_0100, 32'h0000_0003, 32'h0, 1'b0), 1'b0, '0},
         // LSR #0 acts as LSR #32
         '{make_request(32'hE711_2021, 32'h0000_4000, 32'hFFFF_FFFF, 32'h0, 1'b1), 1'b0, '0},
         // ASR #0 acts as ASR #32, negative then positive Rm
         '{make_request(32'hE791_2041, 32'h0000_4000, 32'h8000_0000, 32'h0, 1'b0), 1'b0, '0},
         '{make_request(32'hE791_2041, 32'h0000_4000, 32'h7FFF_FFFF, 32'h0, 1'b1), 1'b0, '0},
         // ASR #5 negative
         '{make_request(32'hE791_22C1, 32'h0000_4000, 32'h8000_0040, 32'h0, 1'b0), 1'b0, '0},
         // ROR #0 is RRX, carry in set and clear
         '{make_request(32'hE791_2061, 32'h0000_4000, 32'h0000_0003, 32'h0, 1'b1), 1'b0, '0},
         '{make_request(32'hE791_2061, 32'h0000_4000, 32'h0000_0003, 32'h0, 1'b0), 1'b0, '0},
         // ROR #8 and ROR #31
         '{make_request(32'hE791_2461, 32'h0000_4000, 32'h1234_5678, 32'h0, 1'b0), 1'b0, '0},
         '{make_request(32'hE791_2FE1, 32'h0000_4000, 32'h8000_0001, 32'h0, 1'b1), 1'b0, '0},
         // STRB scaled LSL #31, subtract, pre-index writeback
         '{make_request(32'hE763_4F8E, 32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0),
           1'b0, '0},
         // scaled register post-index: address is the old base
         '{make_request(32'hE681_2102, 32'h0000_2000, 32'h0000_0010, 32'hA5A5_A5A5, 1'b0),
           1'b0, '0},
         // LDRH immediate, aligned
         '{make_request(32'hE1D1_20B4, 32'h0000_2000, 32'h0, 32'h0, 1'b0), 1'b0, '0},
         // STRH [r3,#3]! on an even base: odd address aborts, no writeback
         '{make_request(32'hE1E3_40B3, 32'h0000_0100, 32'h0, 32'hCAFE_F00D, 1'b0), 1'b1,
           make_result(32'h0000_0103, SIZE_HALF, 1'b0, 4'd4, 4'd3, 1'b0,
                       32'h0000_0100, 32'h0000_F00D, STATUS_ABORT)},
         // LDRH post-index from an odd base aborts too
         '{make_request(32'hE015_60B7, 32'h0000_1001, 32'h0000_0010, 32'h0, 1'b0), 1'b1,
           make_result(32'h0000_1001, SIZE_HALF, 1'b1, 4'd6, 4'd5, 1'b0,
                       32'h0000_1001, 32'h0, STATUS_ABORT)},
         // STRH largest split immediate, subtract, post-index (W ignored)
         '{make_request(32'hE068_9FBF, 32'h0000_0010, 32'h0, 32'hFFFF_FFFF, 1'b0), 1'b0, '0},
         // LDRH register offset, pre-index writeback
         '{make_request(32'hE1BA_B0BC, 32'h0000_0002, 32'h0000_0004, 32'h0, 1'b0), 1'b0, '0},
         // misaligned word: no abort
         '{make_request(32'hE591_2003, 32'h0000_1000, 32'h0, 32'h0, 1'b0), 1'b0, '0},
         // all-zero and all-one beats
         '{make_request(32'h0000_0000, 32'h0, 32'h0, 32'h0, 1'b0), 1'b0, '0},
         '{make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1),
           1'b0, '0}
      };

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      tx_idle_pct = 20;
      foreach (directed_rows[i])
         send_beat(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);

      for (int i = 0; i < RANDOM_BEATS; i++) begin
         if (i % 50 == 0) begin
            case ($urandom_range(0, 2))
               0:       tx_idle_pct = 0;
               1:       tx_idle_pct = 15;
               default: tx_idle_pct = 40;
            endcase
         end
         if (i == 150) begin
            // back-pressure: output held off while beats keep coming
            tx_idle_pct = 0;
            hold_requests++;
         end
         if (i == 350) begin
            // let the pipe run dry before going on
            req_tvalid <= 1'b0;
            do @(negedge clock); while (expected_access.size() != 0);
         end
         send_beat(random_request(), 1'b0, '0);
      end
      req_tvalid <= 1'b0;

      while (expected_access.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d beats: %0d directed, random %0d word/byte, %0d halfword, %0d raw",
               beats_sent, directed_rows.size(), wordbyte_rand, half_rand, raw_rand);
      $display("Checked %0d results: %0d halfword aborts, %0d writebacks, %0d input stalls",
               results_seen, aborts_seen, writebacks, in_stalls);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
